// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with reset disable.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication with reset disable.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/scds_pkg.sv
package scds_pkg;

    localparam int RATE_BITS_DEF = 28;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DEC_BITS      = 16;
    localparam int MAX_CAND      = 1024;
    localparam int CAND_BITS     = 11;

    localparam logic [31:0] RST_BASE_LOW  = 32'd150000000;
    localparam logic [31:0] RST_BASE_HIGH = 32'd180000000;
    localparam logic [31:0] RST_BASE_STEP = 32'd1000000;
    localparam logic [15:0] RST_MAX_DEC   = 16'd10000;
    localparam logic [31:0] RST_CEILING   = 32'd180000000;

    typedef enum logic [2:0]
    {
        REG_BASE_LOW  = 3'd0,
        REG_BASE_HIGH = 3'd1,
        REG_BASE_STEP = 3'd2,
        REG_MAX_DEC   = 3'd3,
        REG_CEILING   = 3'd4
    } reg_idx_t;

    // Handshake between the sequencer and the serial units (divider and multiplier).
    typedef struct packed
    {
        logic start;
    } div_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/scds_divider.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module scds_divider
    import scds_pkg::*;
#(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    input  logic [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0] denom,
    output div_stat_t           stat,
    output logic [NUM_BITS-1:0] quot,
    output logic [DEN_BITS-1:0] remain
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS+1:0] diff;

    always_comb
    begin
        trial = {rem_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
    end

    always_comb
    begin
        q_next    = q_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = numer;
            den_next  = denom;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_BITS+1])
            begin
                rem_next = diff[DEN_BITS:0];
                q_next   = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;
    assign remain    = rem_reg[DEN_BITS-1:0];

endmodule

// File: design/scds_serial_mult.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module scds_serial_mult
    import scds_pkg::*;
#(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    input  logic [A_BITS-1:0]        mcand,
    input  logic [B_BITS-1:0]        mplier,
    output div_stat_t                stat,
    output logic [A_BITS+B_BITS-1:0] prod
);

    localparam int P_BITS   = A_BITS + B_BITS;
    localparam int CNT_BITS = $clog2(B_BITS + 1);

    logic [P_BITS-1:0]   acc_reg, acc_next;
    logic [P_BITS-1:0]   a_reg, a_next;
    logic [B_BITS-1:0]   b_reg, b_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = P_BITS'(mcand);
            b_next    = mplier;
            cnt_next  = CNT_BITS'(B_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[P_BITS-2:0], 1'b0};
            b_next   = {1'b0, b_reg[B_BITS-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// File: design/sample_clock_decimation_selector.sv
// Sample clock decimation selector.
// Input channel: requested_rate (signed Hz) with in_valid / in_stall. The block
// takes one request at a time; in_stall is high from acceptance until the result
// transfer on the output channel completes.
// Output channel: chosen_base_rate, decimation, effective_rate (Q.FRAC_BITS Hz)
// with out_valid / out_stall. The result is held in output registers until the
// receiver drops out_stall; a stalled result does not change.
// Config port: cfg_we / cfg_index / cfg_data; the user must write it only while
// idle, the block itself does not enforce this. Per request: each candidate base
// rate runs one serial divide for the factor, a serial multiply r*f and two
// serial multiplies for the rational compare, plus the ST_DEC and ST_NEXT
// sequencing states. After the last candidate a final divide gives the effective
// rate, then out_valid rises. The default settings give 31 candidates; the count
// is capped at 1024. One shared divider and one shared shift-add multiplier
// serve all these steps.
// Turnaround: the next request can be taken in the cycle after the result transfer.
// Reset: the state and the configuration registers return to their package defaults; no item in flight.
module sample_clock_decimation_selector
    import scds_pkg::*;
#(
    parameter int RATE_BITS = RATE_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [RATE_BITS-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [RATE_BITS:0]     requested_rate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [RATE_BITS-1:0]          chosen_base_rate,
    output logic [DEC_BITS-1:0]           decimation,
    output logic [RATE_BITS+FRAC_BITS-1:0] effective_rate
);

    localparam int RB    = RATE_BITS;
    localparam int DIVN  = RB + FRAC_BITS + 1;   // numerator width
    localparam int DIVD  = RB + 2;               // denominator width
    localparam int MA    = RB + 2;               // unused; multiplier operand A is ERRB wide
    localparam int MB    = DEC_BITS;             // multiplier operand B
    localparam int ERRB  = RB + DEC_BITS + 1;    // error term width

    typedef enum logic [8:0]
    {
        ST_IDLE  = 9'b000000001,
        ST_FDIV  = 9'b000000010,
        ST_RF    = 9'b000000100,
        ST_CMP1  = 9'b000001000,
        ST_CMP2  = 9'b000010000,
        ST_DEC   = 9'b000100000,
        ST_NEXT  = 9'b001000000,
        ST_EDIV  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [RB-1:0]       low_reg, high_reg, step_reg, ceil_reg;
    logic [DEC_BITS-1:0] maxd_reg;

    // working registers
    logic [RB-1:0]        r_reg, r_next;
    logic [RB:0]          b_reg, b_next;      // extra bit for overflow past high
    logic [DEC_BITS-1:0]  f_reg, f_next;
    logic [ERRB-1:0]      e_reg, e_next;
    logic [ERRB+DEC_BITS-1:0] lhs_reg, lhs_next;
    logic                 have_reg, have_next;
    logic [CAND_BITS-1:0] cnt_reg, cnt_next;
    logic [RB-1:0]        bb_reg, bb_next;
    logic [DEC_BITS-1:0]  bf_reg, bf_next;
    logic [ERRB-1:0]      be_reg, be_next;
    logic [RB+FRAC_BITS-1:0] q_reg, q_next;

    // serial units
    div_req_t             dreq, mreq;
    div_stat_t            dstat, mstat;
    logic [DIVN-1:0]      dnum, dquot;
    logic [DIVD-1:0]      dden, drem;
    logic [ERRB-1:0]      ma;
    logic [MB-1:0]        mb;
    logic [ERRB+MB-1:0]   mprod;

    logic [DEC_BITS-1:0]  maxd;
    logic [RB:0]          mag;
    logic [RB-1:0]        r_sat;
    logic [DIVN-1:0]      fq;
    logic [DIVD:0]        rem2;
    logic [ERRB-1:0]      rf;
    logic [RB:0]          b_step;

    assign maxd = (maxd_reg == '0) ? DEC_BITS'(1) : maxd_reg;
    assign mag  = requested_rate[RB] ? (RB+1)'(-requested_rate) : requested_rate;
    assign r_sat = (mag > {1'b0, ceil_reg}) ? ceil_reg : mag[RB-1:0];
    assign rf   = mprod[ERRB-1:0];
    assign b_step = b_reg + {1'b0, step_reg};
    assign rem2 = {drem, 1'b0};

    // clamped factor from the divide quotient
    always_comb
    begin
        fq = dquot;
        if (fq == '0)
        begin
            fq = DIVN'(1);
        end
        if (fq > DIVN'(maxd))
        begin
            fq = DIVN'(maxd);
        end
    end

    scds_divider #(.NUM_BITS(DIVN), .DEN_BITS(DIVD)) u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dreq),
        .numer  (dnum),
        .denom  (dden),
        .stat   (dstat),
        .quot   (dquot),
        .remain (drem)
    );

    scds_serial_mult #(.A_BITS(ERRB), .B_BITS(MB)) u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .mcand  (ma),
        .mplier (mb),
        .stat   (mstat),
        .prod   (mprod)
    );

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        f_next     = f_reg;
        e_next     = e_reg;
        lhs_next   = lhs_reg;
        have_next  = have_reg;
        cnt_next   = cnt_reg;
        bb_next    = bb_reg;
        bf_next    = bf_reg;
        be_next    = be_reg;
        q_next     = q_reg;
        dreq.start = 1'b0;
        mreq.start = 1'b0;
        dnum       = '0;
        dden       = '0;
        ma         = '0;
        mb         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    r_next     = r_sat;
                    b_next     = {1'b0, low_reg};
                    have_next  = 1'b0;
                    cnt_next   = '0;
                    bf_next    = DEC_BITS'(1);
                    be_next    = '0;
                    state_next = ST_FDIV;
                    // factor = (2b + r) / (2r)
                    dreq.start = 1'b1;
                    dnum = DIVN'({low_reg, 1'b0}) + DIVN'(r_sat);
                    dden = DIVD'({r_sat, 1'b0});
                end
            end
            ST_FDIV:
            begin
                if (dstat.done)
                begin
                    f_next     = (r_reg == '0) ? maxd : fq[DEC_BITS-1:0];
                    state_next = ST_RF;
                    mreq.start = 1'b1;
                    ma = ERRB'(r_reg);
                    mb = (r_reg == '0) ? maxd : fq[DEC_BITS-1:0];
                end
            end
            ST_RF:
            begin
                if (mstat.done)
                begin
                    e_next = (ERRB'(b_reg) >= rf) ? ERRB'(b_reg) - rf : rf - ERRB'(b_reg);
                    state_next = ST_CMP1;
                    mreq.start = 1'b1;
                    ma = (ERRB'(b_reg) >= rf) ? ERRB'(b_reg) - rf : rf - ERRB'(b_reg);
                    mb = bf_reg;
                end
            end
            ST_CMP1:
            begin
                if (mstat.done)
                begin
                    lhs_next   = mprod;
                    state_next = ST_CMP2;
                    mreq.start = 1'b1;
                    ma = be_reg;
                    mb = f_reg;
                end
            end
            ST_CMP2:
            begin
                if (mstat.done)
                begin
                    if (!have_reg || lhs_reg < mprod)
                    begin
                        have_next = 1'b1;
                        bb_next   = b_reg[RB-1:0];
                        bf_next   = f_reg;
                        be_next   = e_reg;
                    end
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (step_reg == '0 || cnt_reg >= CAND_BITS'(MAX_CAND)
                    || b_step > {1'b0, high_reg})
                begin
                    state_next = ST_EDIV;
                    dreq.start = 1'b1;
                    dnum = DIVN'({bb_reg, {FRAC_BITS{1'b0}}});
                    dden = DIVD'(bf_reg);
                end
                else
                begin
                    b_next     = b_step;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = ST_FDIV;
                dreq.start = 1'b1;
                dnum = DIVN'({b_reg, 1'b0}) + DIVN'(r_reg);
                dden = DIVD'({r_reg, 1'b0});
            end
            ST_EDIV:
            begin
                if (dstat.done)
                begin
                    // round half up: rem >= f - rem  <=>  2*rem >= f
                    q_next = dquot[RB+FRAC_BITS-1:0]
                           + ((rem2 >= (DIVD+1)'(bf_reg)) ? 1'b1 : 1'b0);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            low_reg   <= RB'(RST_BASE_LOW);
            high_reg  <= RB'(RST_BASE_HIGH);
            step_reg  <= RB'(RST_BASE_STEP);
            maxd_reg  <= RST_MAX_DEC;
            ceil_reg  <= RB'(RST_CEILING);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_LOW:  low_reg  <= cfg_data;
                    REG_BASE_HIGH: high_reg <= cfg_data;
                    REG_BASE_STEP: step_reg <= cfg_data;
                    REG_MAX_DEC:   maxd_reg <= cfg_data[DEC_BITS-1:0];
                    REG_CEILING:   ceil_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        b_reg    <= b_next;
        f_reg    <= f_next;
        e_reg    <= e_next;
        lhs_reg  <= lhs_next;
        have_reg <= have_next;
        cnt_reg  <= cnt_next;
        bb_reg   <= bb_next;
        bf_reg   <= bf_next;
        be_reg   <= be_next;
        q_reg    <= q_next;
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = (state_reg == ST_OUT);
    assign chosen_base_rate = bb_reg;
    assign decimation       = bf_reg;
    assign effective_rate   = q_reg;

endmodule

// File: design/scds_checker.sv
`include "assert_macros.svh"

module scds_checker
    import scds_pkg::*;
#(
    parameter int RATE_BITS = RATE_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [RATE_BITS-1:0]           chosen_base_rate,
    input logic [DEC_BITS-1:0]            decimation,
    input logic [RATE_BITS+FRAC_BITS-1:0] effective_rate
);

    `ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall, "input taken while result pending")
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(chosen_base_rate) && $stable(decimation) && $stable(effective_rate), "stalled result changed")
    `ASSERT_IMPL(a_dec_nonzero, clk, rst_n, out_valid, decimation != '0, "zero decimation")
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after transfer")

endmodule

bind sample_clock_decimation_selector scds_checker #(
    .RATE_BITS(RATE_BITS),
    .FRAC_BITS(FRAC_BITS)
) u_scds_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .chosen_base_rate (chosen_base_rate),
    .decimation       (decimation),
    .effective_rate   (effective_rate)
);

// File: bench/sample_clock_decimation_selector_tb.sv
`timescale 1ns / 1ps

// Bench for the decimation selector: a directed table at reset defaults, then
// config phases (extremes, long candidate walk, degenerate registers, random
// settings) with random requests. Each result is checked in order against a
// typed-in answer or a local exact-arithmetic predictor.
module sample_clock_decimation_selector_tb
    import scds_pkg::*;
();

    localparam int RB = RATE_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint unsigned RMASK = (64'd1 << RB) - 1;
    localparam longint unsigned IMASK = (64'd1 << (RB + 1)) - 1;
    localparam longint unsigned CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [RB-1:0]      base;
        logic [DEC_BITS-1:0] dec;
        logic [RB+FB-1:0]   eff;
    } selection_t;

    // directed row: request, and an optional typed-in answer
    typedef struct {
        logic signed [RB:0] rate;
        bit                 typed;
        selection_t         sel;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [2:0]             cfg_index;
    logic [RB-1:0]          cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [RB:0]     requested_rate;
    logic                   out_valid;
    logic                   out_stall;
    logic [RB-1:0]          chosen_base_rate;
    logic [DEC_BITS-1:0]    decimation;
    logic [RB+FB-1:0]       effective_rate;

    // shadow of the block's registers
    longint unsigned base_low, base_high, base_step, dec_max, ceiling;

    selection_t pending_sel[$];
    int         mismatches;
    bit         quiet;       // no idling on either side while set
    bit         long_hold;   // receiver holds off for a long stretch next
    longint unsigned cycles = 0;

    sample_clock_decimation_selector u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .requested_rate   (requested_rate),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chosen_base_rate (chosen_base_rate),
        .decimation       (decimation),
        .effective_rate   (effective_rate)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Walk the candidate base rates and keep the one closest to the request.
    // Distances compare as e/f, cross-multiplied so the test stays exact.
    function automatic selection_t pick_base_and_dec(logic signed [RB:0] req);
        longint unsigned v, r, b, maxd, best_b, best_f, best_e, f, rf, e, num, q, rem;
        bit   have;
        int   visited;
        selection_t s;
        v = longint'(req) & IMASK;
        r = v[RB] ? ((~v) + 1) & IMASK : v;
        if (r > ceiling)
            r = ceiling;
        maxd = (dec_max != 0) ? dec_max : 1;
        have = 0;
        visited = 0;
        best_b = base_low;
        best_f = 1;
        best_e = 0;
        b = base_low;
        forever
        begin
            if (r == 0)
                f = maxd;
            else
            begin
                f = (2 * b + r) / (2 * r);    // round half up
                if (f < 1)
                    f = 1;
                if (f > maxd)
                    f = maxd;
            end
            rf = r * f;
            e = (b >= rf) ? b - rf : rf - b;
            if (!have || e * best_f < best_e * f)
            begin
                have = 1;
                best_b = b;
                best_f = f;
                best_e = e;
            end
            visited++;
            if (base_step == 0 || visited >= MAX_CAND)
                break;
            b += base_step;
            if (b > base_high)
                break;
        end
        num = best_b << FB;
        q = num / best_f;
        rem = num % best_f;
        if (rem >= best_f - rem)
            q++;
        s.base = best_b[RB-1:0];
        s.dec  = best_f[DEC_BITS-1:0];
        s.eff  = q[RB+FB-1:0];
        return s;
    endfunction

    task automatic write_reg(reg_idx_t idx, longint unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[RB-1:0];
        @(posedge clk);
        case (idx)
            REG_BASE_LOW:  base_low  = value & RMASK;
            REG_BASE_HIGH: base_high = value & RMASK;
            REG_BASE_STEP: base_step = value & RMASK;
            REG_MAX_DEC:   dec_max   = value & 16'hffff;
            REG_CEILING:   ceiling   = value & RMASK;
            default: ;
        endcase
    endtask

    // Registers change only once the block has drained every transfer.
    task automatic load_settings(longint unsigned lo, longint unsigned hi,
                                 longint unsigned st, longint unsigned md,
                                 longint unsigned ce);
        in_valid <= 1'b0;
        while (pending_sel.size() != 0)
            @(posedge clk);
        @(posedge clk);
        write_reg(REG_BASE_LOW, lo);
        write_reg(REG_BASE_HIGH, hi);
        write_reg(REG_BASE_STEP, st);
        write_reg(REG_MAX_DEC, md);
        write_reg(REG_CEILING, ce);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One input transfer; the expectation is queued at acceptance so it sees
    // the registers that the block saw.
    task automatic offer_rate(logic signed [RB:0] rate, bit typed, selection_t sel);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        requested_rate <= rate;
        do
            @(posedge clk);
        while (in_stall);
        pending_sel.insert(pending_sel.size(), typed ? sel : pick_base_and_dec(rate));
    endtask

    function automatic logic signed [RB:0] random_rate();
        logic signed [RB:0] x;
        longint unsigned f;
        case ($urandom_range(0, 5))
            0: x = (RB+1)'($urandom());                          // any 29-bit pattern
            1: x = (RB+1)'($urandom_range(0, 2000));
            2: x = -$signed({1'b0, RB'($urandom_range(0, 100000))});
            3:
            begin
                // near base / f for some candidate, where ties and rounding live
                f = $urandom_range(1, 40);
                x = (RB+1)'((base_low + base_step * $urandom_range(0, 4)) / f
                            + $urandom_range(0, 6) - 3);
            end
            4: x = (RB+1)'(ceiling + $urandom_range(0, 3) - 1);
            default: x = (RB+1)'($urandom_range(0, 32'h0fffffff));
        endcase
        if ($urandom_range(0, 3) == 0)
            x = -x;
        return x;
    endfunction

    task automatic random_rates(int n);
        selection_t unused;
        repeat (n) offer_rate(random_rate(), 1'b0, unused);
    endtask

    // Receiver: draws a hold-off per transfer, and checks in order.
    initial
    begin : result_checker
        int n;
        selection_t want;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 19);
            if (long_hold)
            begin
                // long stall so that the sender backs up behind a full block
                n = 6000;
                long_hold = 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_sel.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: base %0d dec %0d eff %0d",
                             chosen_base_rate, decimation, effective_rate);
            end
            else
            begin
                want = pending_sel.pop_front();
                if (chosen_base_rate !== want.base || decimation !== want.dec ||
                    effective_rate !== want.eff)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected base %0d dec %0d eff %0d, got %0d %0d %0d",
                                 want.base, want.dec, want.eff,
                                 chosen_base_rate, decimation, effective_rate);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t   dir_table [12];
        selection_t none;
        mismatches = 0;
        quiet = 0;
        long_hold = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BASE_LOW;
        cfg_data = '0;
        in_valid = 1'b0;
        requested_rate = '0;
        out_stall = 1'b0;
        base_low  = RST_BASE_LOW;
        base_high = RST_BASE_HIGH;
        base_step = RST_BASE_STEP;
        dec_max   = RST_MAX_DEC;
        ceiling   = RST_CEILING;
        none = '{default: '0};

        // zero request: every factor is the maximum, lowest base wins
        dir_table[0] = '{29'sd0, 1'b1, '{28'd150000000, 16'd10000, 44'd983040000}};
        // exact hit on the low base rate
        dir_table[1] = '{29'sd150000000, 1'b1,
                         '{28'd150000000, 16'd1, 44'd9830400000000}};
        // negative request of magnitude 2^28 - 1 saturates to the ceiling
        dir_table[2] = '{-29'sd268435455, 1'b1,
                         '{28'd180000000, 16'd1, 44'd11796480000000}};
        dir_table[3] = '{29'sd268435455, 1'b1,
                         '{28'd180000000, 16'd1, 44'd11796480000000}};
        dir_table[4] = '{29'sd1, 1'b0, none};
        dir_table[5] = '{-29'sd1, 1'b0, none};
        dir_table[6] = '{29'sd165432100, 1'b0, none};
        dir_table[7] = '{-29'sd33333333, 1'b0, none};
        dir_table[8] = '{29'sd15500, 1'b0, none};
        dir_table[9] = '{29'sd17000000, 1'b0, none};
        dir_table[10] = '{29'sd16500000, 1'b0, none};      // a rounding midpoint
        dir_table[11] = '{-29'sd268435456, 1'b0, none};    // sign bit only

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            offer_rate(dir_table[i].rate, dir_table[i].typed, dir_table[i].sel);

        // extremes: one candidate, widest factor range and ceiling
        load_settings(1, 28'hfffffff, 28'hfffffff, 65535, 28'hfffffff);
        random_rates(30);
        // full-scale single candidate with smallest limits
        load_settings(28'hfffffff, 28'hfffffff, 1, 1, 1);
        random_rates(10);
        // longest walk: candidate count hits the cap
        load_settings(1000, 28'hfffffff, 1, 65535, 28'hfffffff);
        random_rates(2);
        // zero step, zero base rate
        load_settings(0, 1000, 0, 100, 5000);
        random_rates(12);
        // low above high, zero max decimation
        load_settings(90000000, 10000000, 3000000, 0, 200000000);
        random_rates(12);

        // back-pressure: receiver stalls while the sender keeps offering
        load_settings(RST_BASE_LOW, 150000000 + 4 * 1000000, RST_BASE_STEP, 10000,
                      RST_CEILING);
        long_hold = 1;
        random_rates(6);

        // random settings with short candidate lists
        repeat (7)
        begin
            longint unsigned lo, st;
            lo = $urandom_range(1, 28'hfffffff);
            st = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 1000)
                                              : $urandom_range(1, 28'h0ffffff);
            quiet = ($urandom_range(0, 2) == 0);
            load_settings(lo, lo + st * $urandom_range(0, 7), st,
                          ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 65535),
                          $urandom_range(1, 28'hfffffff));
            random_rates(30);
        end
        quiet = 0;
        in_valid <= 1'b0;

        while (pending_sel.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
